@@ hdl/v2dd_pkg.sv @@
// ----------------------------------------------------------------------------
// v2dd_pkg
// shared types, constants and the arctangent table of the drive controller
// ----------------------------------------------------------------------------
package v2dd_pkg;

  localparam int TableLen = 20;
  localparam int AngW = 20;
  localparam int CordW = 28;

  localparam logic signed [AngW-1:0] AngPi = 20'sd205887;
  localparam logic signed [AngW-1:0] AngHalfPi = 20'sd102944;
  localparam logic signed [AngW-1:0] AngTwoPi = 20'sd411775;
  localparam logic [15:0] InvGain = 16'd39797;

  localparam logic [2:0] RegTol = 3'd0;
  localparam logic [2:0] RegTurnScale = 3'd1;
  localparam logic [2:0] RegTurnGain = 3'd2;
  localparam logic [2:0] RegTrackGain = 3'd3;
  localparam logic [2:0] RegMaxLin = 3'd4;
  localparam logic [2:0] RegMaxAng = 3'd5;

  typedef struct packed {
    logic [14:0] tol;
    logic [15:0] turn_scale;
    logic [15:0] turn_gain;
    logic [15:0] track_gain;
    logic [14:0] max_lin;
    logic [14:0] max_ang;
  } cfg_t;

  // carried alongside the cordic data
  typedef struct packed {
    logic zero;
    logic turn;
    logic neg;
    logic signed [AngW-1:0] err;
  } side_t;

  function automatic logic signed [AngW-1:0] atan_lut(input int i);
    logic signed [AngW-1:0] r;
    begin
      unique case (i)
        0: r = 20'sd51472;
        1: r = 20'sd30386;
        2: r = 20'sd16055;
        3: r = 20'sd8150;
        4: r = 20'sd4091;
        5: r = 20'sd2047;
        6: r = 20'sd1024;
        7: r = 20'sd512;
        8: r = 20'sd256;
        9: r = 20'sd128;
        10: r = 20'sd64;
        11: r = 20'sd32;
        12: r = 20'sd16;
        13: r = 20'sd8;
        14: r = 20'sd4;
        15: r = 20'sd2;
        16: r = 20'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ hdl/vector_to_differential_drive.sv @@
// ----------------------------------------------------------------------------
// vector_to_differential_drive
// planar velocity vector and heading to a differential-drive command
// ----------------------------------------------------------------------------
// channel  | dir | contents
// s_axis   | in  | tdata: vel_x, vel_y, heading
// m_axis   | out | tdata: linear_speed, angular_speed; tuser: zero_vector, turning_mode
// cfg      | in  | cfg_we, cfg_index, cfg_data (six registers)
//
// one transaction per cycle sustained while the output is free or taken; data
// runs through the vectoring and rotation cordic chains plus the multiplier stages
// the whole pipeline advances together when the output register is free or
// taken; a stall freezes every stage, nothing lost or repeated
// rst clears the valid bits and loads register reset values
// ----------------------------------------------------------------------------
module vector_to_differential_drive #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // vel_x[15:0], vel_y[31:16], heading[47:32]
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata,  // linear_speed[14:0], angular_speed[30:15],
                                     // zero pad[31]
  output logic [1:0] m_axis_tuser,   // zero_vector[0], turning_mode[1]
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import v2dd_pkg::*;

  localparam int N = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
  localparam int Depth = 2 * N + 7;

  cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{tol: 15'd2458, turn_scale: 16'd819, turn_gain: 16'd8192,
               track_gain: 16'd4096, max_lin: 15'd4096, max_ang: 15'd8192};
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTol:       cfg.tol <= cfg_data[14:0];
        RegTurnScale: cfg.turn_scale <= cfg_data;
        RegTurnGain:  cfg.turn_gain <= cfg_data;
        RegTrackGain: cfg.track_gain <= cfg_data;
        RegMaxLin:    cfg.max_lin <= cfg_data[14:0];
        RegMaxAng:    cfg.max_ang <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // global enable: pipeline moves when output slot empty or being taken
  logic en;
  logic [Depth-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], s_axis_tvalid};
  end

  // stage 0: quadrant pre-rotation
  logic signed [15:0] in_vx, in_vy, in_hd;
  assign in_vx = s_axis_tdata[15:0];
  assign in_vy = s_axis_tdata[31:16];
  assign in_hd = s_axis_tdata[47:32];

  logic signed [CordW-1:0] vx_s [N+1];
  logic signed [CordW-1:0] vy_s [N+1];
  logic signed [AngW-1:0] vz_s [N+1];
  logic signed [15:0] hd_s [N+1];
  logic zero_s [N+1];

  logic signed [CordW-1:0] px, py;
  assign px = CordW'(in_vx) <<< 8;
  assign py = CordW'(in_vy) <<< 8;

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_vx < 0) begin
        if (in_vy >= 0) begin
          vx_s[0] <= py; vy_s[0] <= -px; vz_s[0] <= AngHalfPi;
        end else begin
          vx_s[0] <= -py; vy_s[0] <= px; vz_s[0] <= -AngHalfPi;
        end
      end else begin
        vx_s[0] <= px; vy_s[0] <= py; vz_s[0] <= '0;
      end
      hd_s[0] <= in_hd;
      zero_s[0] <= (in_vx == 0) && (in_vy == 0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    v2dd_vec_stage #(.Idx(i)) u_stage (
      .clk(clk), .en(en),
      .x_in(vx_s[i]), .y_in(vy_s[i]), .z_in(vz_s[i]), .hd_in(hd_s[i]),
      .zero_in(zero_s[i]),
      .x(vx_s[i+1]), .y(vy_s[i+1]), .z(vz_s[i+1]), .hd(hd_s[i+1]),
      .zero(zero_s[i+1])
    );
  end

  // magnitude multiply and heading error
  logic signed [CordW+16:0] mag_prod;
  logic signed [AngW-1:0] err_raw;
  logic [15:0] mag_a;
  logic signed [AngW-1:0] err_a;
  logic zero_a;
  assign mag_prod = vx_s[N] * $signed({1'b0, InvGain});
  assign err_raw = vz_s[N] - (AngW'(hd_s[N]) <<< 3);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= mag_prod[39:24];
      zero_a <= zero_s[N];
      if (err_raw > AngPi) err_a <= err_raw - AngTwoPi;
      else if (err_raw < -AngPi) err_a <= err_raw + AngTwoPi;
      else err_a <= err_raw;
    end
  end

  // mode decision and rotation pre-fold
  logic signed [CordW-1:0] rx_s [N+1];
  logic signed [CordW-1:0] ry_s [N+1];
  logic signed [AngW-1:0] rz_s [N+1];
  logic [15:0] mag_s [N+1];
  side_t side_s [N+1];
  logic signed [AngW-1:0] aerr;
  assign aerr = err_a[AngW-1] ? -err_a : err_a;

  always_ff @(posedge clk) begin
    if (en) begin
      rx_s[0] <= CordW'(InvGain) <<< 8;
      ry_s[0] <= '0;
      mag_s[0] <= mag_a;
      side_s[0].zero <= zero_a;
      side_s[0].err <= err_a;
      side_s[0].turn <= !zero_a && (aerr > $signed({2'b0, cfg.tol, 3'b0}));
      if (err_a > AngHalfPi) begin
        rz_s[0] <= err_a - AngPi; side_s[0].neg <= 1'b1;
      end else if (err_a < -AngHalfPi) begin
        rz_s[0] <= err_a + AngPi; side_s[0].neg <= 1'b1;
      end else begin
        rz_s[0] <= err_a; side_s[0].neg <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    v2dd_rot_stage #(.Idx(i)) u_stage (
      .clk(clk), .en(en),
      .x_in(rx_s[i]), .y_in(ry_s[i]), .z_in(rz_s[i]), .mag_in(mag_s[i]),
      .side_in(side_s[i]),
      .x(rx_s[i+1]), .y(ry_s[i+1]), .z(rz_s[i+1]), .mag(mag_s[i+1]),
      .side(side_s[i+1])
    );
  end

  // cos clamp and first products
  logic signed [CordW-1:0] c_raw, c_neg;
  logic signed [17:0] cosv;
  logic [15:0] mag_b;
  side_t side_b;
  assign c_raw = rx_s[N] >>> 8;
  assign c_neg = side_s[N].neg ? -c_raw : c_raw;

  always_ff @(posedge clk) begin
    if (en) begin
      if (c_neg > 65536) cosv <= 18'sd65536;
      else if (c_neg < -65536) cosv <= -18'sd65536;
      else cosv <= c_neg[17:0];
      mag_b <= mag_s[N];
      side_b <= side_s[N];
    end
  end

  logic signed [34:0] lin_prod;
  logic signed [36:0] ang_prod;
  logic signed [18:0] lin_c;
  logic signed [20:0] ang_c;
  side_t side_c;
  assign lin_prod = $signed({1'b0, mag_b}) * cosv;
  assign ang_prod = $signed({1'b0, side_b.turn ? cfg.turn_gain : cfg.track_gain})
                    * side_b.err;

  always_ff @(posedge clk) begin
    if (en) begin
      lin_c <= lin_prod[34:16];
      ang_c <= ang_prod[36:16];
      side_c <= side_b;
    end
  end

  // turn scale product
  logic signed [35:0] sc_prod;
  logic signed [23:0] lin_d;
  logic signed [20:0] ang_d;
  side_t side_d;
  assign sc_prod = lin_c * $signed({1'b0, cfg.turn_scale});

  always_ff @(posedge clk) begin
    if (en) begin
      lin_d <= side_c.turn ? sc_prod[35:12] : 24'(lin_c);
      ang_d <= ang_c;
      side_d <= side_c;
    end
  end

  // saturation into output register
  logic [14:0] lin_o;
  logic signed [15:0] ang_o;
  logic zero_o, turn_o;
  logic signed [20:0] maxa;
  assign maxa = $signed({6'b0, cfg.max_ang});

  always_ff @(posedge clk) begin
    if (en) begin
      zero_o <= side_d.zero;
      turn_o <= side_d.turn;
      if (side_d.zero) begin
        lin_o <= '0;
        ang_o <= '0;
      end else begin
        if (lin_d < 0) lin_o <= '0;
        else if (lin_d > $signed({9'b0, cfg.max_lin})) lin_o <= cfg.max_lin;
        else lin_o <= lin_d[14:0];
        if (ang_d > maxa) ang_o <= maxa[15:0];
        else if (ang_d < -maxa) ang_o <= 16'(-maxa);
        else ang_o <= ang_d[15:0];
      end
    end
  end

  assign m_axis_tdata = {1'b0, ang_o, lin_o};
  assign m_axis_tuser = {turn_o, zero_o};
endmodule

@@ hdl/v2dd_vec_stage.sv @@
// ----------------------------------------------------------------------------
// v2dd_vec_stage
// one registered vectoring cordic iteration
// ----------------------------------------------------------------------------
module v2dd_vec_stage #(
  parameter int Idx = 0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [v2dd_pkg::CordW-1:0] x_in,
  input  logic signed [v2dd_pkg::CordW-1:0] y_in,
  input  logic signed [v2dd_pkg::AngW-1:0] z_in,
  input  logic signed [15:0] hd_in,
  input  logic zero_in,
  output logic signed [v2dd_pkg::CordW-1:0] x,
  output logic signed [v2dd_pkg::CordW-1:0] y,
  output logic signed [v2dd_pkg::AngW-1:0] z,
  output logic signed [15:0] hd,
  output logic zero
);
  import v2dd_pkg::*;

  logic signed [CordW-1:0] dx, dy;
  assign dx = y_in >>> Idx;
  assign dy = x_in >>> Idx;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + atan_lut(Idx);
      end else begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - atan_lut(Idx);
      end
      hd <= hd_in;
      zero <= zero_in;
    end
  end
endmodule

@@ hdl/v2dd_rot_stage.sv @@
// ----------------------------------------------------------------------------
// v2dd_rot_stage
// one registered rotation cordic iteration carrying magnitude and flags
// ----------------------------------------------------------------------------
module v2dd_rot_stage #(
  parameter int Idx = 0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [v2dd_pkg::CordW-1:0] x_in,
  input  logic signed [v2dd_pkg::CordW-1:0] y_in,
  input  logic signed [v2dd_pkg::AngW-1:0] z_in,
  input  logic [15:0] mag_in,
  input  v2dd_pkg::side_t side_in,
  output logic signed [v2dd_pkg::CordW-1:0] x,
  output logic signed [v2dd_pkg::CordW-1:0] y,
  output logic signed [v2dd_pkg::AngW-1:0] z,
  output logic [15:0] mag,
  output v2dd_pkg::side_t side
);
  import v2dd_pkg::*;

  logic signed [CordW-1:0] dx, dy;
  assign dx = y_in >>> Idx;
  assign dy = x_in >>> Idx;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - atan_lut(Idx);
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + atan_lut(Idx);
      end
      mag <= mag_in;
      side <= side_in;
    end
  end
endmodule

@@ hdl/v2dd_checker.sv @@
// ----------------------------------------------------------------------------
// v2dd_checker
// port-level checks of the drive controller
// ----------------------------------------------------------------------------
module v2dd_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);
  // zero vector result carries an all-zero command
  a_zero_cmd: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[30:0] == '0 && !m_axis_tuser[1])
    else $error("zero vector with nonzero command");
  // ready whenever output is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with free output");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");
  // padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("nonzero padding");
endmodule

bind vector_to_differential_drive v2dd_checker u_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

@@ tb/tb_vector_to_differential_drive.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_to_differential_drive
// self-checking bench: velocity vectors and headings in, drive commands out
// ----------------------------------------------------------------------------
// a queue-fed driver offers vector transactions on s_axis while a monitor
// takes commands from m_axis and compares them, field by field, with the
// oldest prediction of a cordic-exact model of the controller. runs through
// several register settings, written only while the pipeline is empty
// ----------------------------------------------------------------------------
module tb_vector_to_differential_drive;
  import v2dd_pkg::*;

  localparam int Stages = 14;
  localparam int Latency = 2 * Stages + 7;
  localparam int CycleLimit = 1000000;
  localparam logic [2:0] SpareIdxLo = 3'd6;
  localparam logic [2:0] SpareIdxHi = 3'd7;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] vy;
    logic signed [15:0] vx;
  } vec_item_t;

  typedef struct {
    logic [14:0] lin;
    logic signed [15:0] ang;
    logic zero;
    logic turn;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // vel_x, vel_y, heading
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // linear_speed, angular_speed, pad
  logic [1:0] m_axis_tuser;   // zero_vector, turning_mode
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  vector_to_differential_drive #(.CORDIC_STAGES(Stages)) dut (.*);

  always #5 clk = ~clk;

  // bench copy of the register file
  longint tol_r, scale_r, tgain_r, kgain_r, maxl_r, maxa_r;

  vec_item_t pending_vecs[$];
  drive_cmd_t expected_cmds[$];
  int n_errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  longint atan_vals[20] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                            128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint cos_of(longint a);
    longint x, y, z, dx, dy, c;
    bit neg;
    x = 39797 * 256; y = 0; z = a; neg = 0;
    if (z > 102944) begin
      z -= 205887; neg = 1;
    end else if (z < -102944) begin
      z += 205887; neg = 1;
    end
    for (int i = 0; i < Stages; i++) begin
      dx = floor_shr(y, i); dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_vals[i];
      end else begin
        x += dx; y -= dy; z += atan_vals[i];
      end
    end
    c = floor_shr(x, 8);
    if (neg) c = -c;
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    return c;
  endfunction

  function automatic drive_cmd_t drive_command(vec_item_t v);
    drive_cmd_t r;
    longint x, y, z, t, dx, dy, mag, err, lin, angv, gain;
    bit turn;
    r = '{lin: '0, ang: '0, zero: 1'b0, turn: 1'b0};
    if (v.vx == 0 && v.vy == 0) begin
      r.zero = 1'b1;
      return r;
    end
    x = longint'(v.vx) * 256; y = longint'(v.vy) * 256; z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 102944;
      end else begin
        t = x; x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < Stages; i++) begin
      dx = floor_shr(y, i); dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_vals[i];
      end else begin
        x -= dx; y += dy; z -= atan_vals[i];
      end
    end
    mag = floor_shr(x * 39797, 24);
    err = z - longint'(v.heading) * 8;
    if (err > 205887) err -= 411775;
    else if (err < -205887) err += 411775;
    turn = ((err < 0) ? -err : err) > tol_r * 8;
    lin = floor_shr(mag * cos_of(err), 16);
    if (turn) begin
      lin = floor_shr(lin * scale_r, 12);
      gain = tgain_r;
    end else begin
      gain = kgain_r;
    end
    if (lin < 0) lin = 0;
    if (lin > maxl_r) lin = maxl_r;
    angv = floor_shr(gain * err, 16);
    if (angv > maxa_r) angv = maxa_r;
    if (angv < -maxa_r) angv = -maxa_r;
    r.lin = lin[14:0];
    r.ang = angv[15:0];
    r.turn = turn;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    n_errors++;
  endtask

  // driver: one transaction per handshake, random gaps between offers
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_vecs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= pending_vecs.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // predictions are made at acceptance, so register state is the live one
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      expected_cmds.insert(expected_cmds.size(), drive_command(vec_item_t'(s_axis_tdata)));
  end

  // receiver back-pressure, with a long hold-off counted here
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected command", 0, 0);
      end else begin
        want = expected_cmds.pop_front();
        if (m_axis_tdata[14:0] !== want.lin)
          report_mismatch("linear_speed", m_axis_tdata[14:0], want.lin);
        if (m_axis_tdata[30:15] !== want.ang)
          report_mismatch("angular_speed", $signed(m_axis_tdata[30:15]), want.ang);
        if (m_axis_tuser[0] !== want.zero)
          report_mismatch("zero_vector", m_axis_tuser[0], want.zero);
        if (m_axis_tuser[1] !== want.turn)
          report_mismatch("turning_mode", m_axis_tuser[1], want.turn);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      RegTol: tol_r = val & 16'h7fff;
      RegTurnScale: scale_r = val & 16'hffff;
      RegTurnGain: tgain_r = val & 16'hffff;
      RegTrackGain: kgain_r = val & 16'hffff;
      RegMaxLin: maxl_r = val & 16'h7fff;
      RegMaxAng: maxa_r = val & 16'h7fff;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_vecs.size() > 0 || s_axis_tvalid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic vec_item_t rand_vec();
    vec_item_t v;
    int k;
    k = $urandom_range(9);
    v.vx = 16'($urandom);
    v.vy = 16'($urandom);
    v.heading = 16'($urandom);
    // mostly moderate vectors; sometimes tiny or full scale
    if (k < 5) begin
      v.vx = 16'($signed($urandom_range(16383)) - 8192);
      v.vy = 16'($signed($urandom_range(16383)) - 8192);
    end else if (k == 5) begin
      v.vx = 16'($signed($urandom_range(6)) - 3);
      v.vy = 16'($signed($urandom_range(6)) - 3);
    end
    return v;
  endfunction

  task automatic add_vec(int vx, int vy, int hd);
    vec_item_t v;
    v.vx = 16'(vx); v.vy = 16'(vy); v.heading = 16'(hd);
    pending_vecs.insert(pending_vecs.size(), v);
  endtask

  task automatic add_random(int count);
    for (int i = 0; i < count; i++) pending_vecs.insert(pending_vecs.size(), rand_vec());
  endtask

  initial begin
    tol_r = 2458; scale_r = 819; tgain_r = 8192; kgain_r = 4096;
    maxl_r = 4096; maxa_r = 8192;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, axes, extremes, wrap around pi, tolerance edge
    add_vec(0, 0, 0);
    add_vec(0, 0, -32768);
    add_vec(4096, 0, 0);
    add_vec(-4096, 0, 0);
    add_vec(0, 4096, 0);
    add_vec(0, -4096, 0);
    add_vec(-32768, -32768, 32767);
    add_vec(32767, 32767, -32768);
    add_vec(-32768, 0, -32768);
    add_vec(-32768, 1, 25736);
    add_vec(-32768, -1, -25736);
    add_vec(4096, 0, 2458);
    add_vec(4096, 0, 2457);
    add_vec(4096, 0, -2458);
    add_vec(4096, 0, -2459);
    add_vec(4096, 0, 12868);
    add_vec(1, 0, 0);
    add_vec(0, -1, 0);
    add_vec(-1, -1, 0);
    add_vec(32767, -32768, 0);
    drain();

    // bench phases: extremes of every register and the spare indices, then random settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(RegTol, 0); write_reg(RegTurnScale, 65535);
          write_reg(RegTurnGain, 65535); write_reg(RegTrackGain, 0);
          write_reg(RegMaxLin, 32767); write_reg(RegMaxAng, 32767);
        end
        1: begin
          write_reg(RegTol, 25736); write_reg(RegTurnScale, 0);
          write_reg(RegTurnGain, 0); write_reg(RegTrackGain, 65535);
          write_reg(RegMaxLin, 0); write_reg(RegMaxAng, 0);
        end
        2: begin
          write_reg(RegTol, 16'hffff); write_reg(RegMaxLin, 16'hffff);
          write_reg(RegMaxAng, 16'hffff);
          write_reg(SpareIdxLo, 16'h1234); write_reg(SpareIdxHi, 16'h4321);
        end
        default: begin
          write_reg(RegTol, $urandom_range(25736));
          write_reg(RegTurnScale, $urandom_range(65535));
          write_reg(RegTurnGain, $urandom_range(65535));
          write_reg(RegTrackGain, $urandom_range(65535));
          write_reg(RegMaxLin, $urandom_range(32767));
          write_reg(RegMaxAng, $urandom_range(32767));
        end
      endcase
      send_idle_pct = (ph % 3 == 0) ? 12 : (ph % 3 == 1) ? 48 : 0;
      recv_idle_pct = (ph % 3 == 0) ? 48 : (ph % 3 == 1) ? 12 : 0;
      if (ph == 5) begin
        // sender pause until all commands are back, then the rest
        add_random(110);
        drain();
        add_random(100);
      end else begin
        add_random(210);
      end
      // long receiver stall so the pipeline fills and s_axis stalls
      if (ph == 3) begin
        while (pending_vecs.size() > 150) @(posedge clk);
        hold_off <= 300;
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/v2dd_pkg.sv
hdl/v2dd_vec_stage.sv
hdl/v2dd_rot_stage.sv
hdl/vector_to_differential_drive.sv
hdl/v2dd_checker.sv
tb/tb_vector_to_differential_drive.sv
